### sv/segment_map_unmap_memory_unit_defines.svh
// Assertion macros for the segment map/unmap memory unit.
// Included by the RTL file that carries concurrent checks; the macros expect clk and rst_n.
`ifndef SEGMENT_MAP_UNMAP_MEMORY_UNIT_DEFINES_SVH
`define SEGMENT_MAP_UNMAP_MEMORY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SMU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SMU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/smu_pkg.sv
// Shared types and constants of the segment map/unmap memory unit.
// No dependencies; every other RTL file except smu_alu imports this package.
`default_nettype none

package smu_pkg;

  // Fixed field widths of the input and result words.
  localparam int KIND_W  = 2;
  localparam int SEGID_W = 6;
  localparam int OFFS_W  = 8;
  localparam int WORD_W  = 32;
  localparam int SIZE_W  = 9;
  localparam int STAT_W  = 3;

  // Default geometry.
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_SLOT_WORDS   = 256;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_MAP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNMAP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STORE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NO_ID      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_BIG    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_STACK_FULL = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_FILL,
    S_READ,
    S_DONE
  } state_t;

  // Write strobes for the segment length table and the free identifier stack.
  typedef struct packed {
    logic len_we;
    logic stk_we;
  } tbl_ctrl_t;

endpackage

`default_nettype wire

### sv/smu_alu.sv
// Shared compare and increment unit of the segment map/unmap memory unit.
// Used by the sequencer for the size, unmap and offset checks and for the fill counter.
`default_nettype none

module smu_alu #(
  parameter int W = 10
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         lt,
  output logic [W-1:0] inc
);

  assign lt  = (a < b);
  assign inc = a + W'(1);

endmodule

`default_nettype wire

### sv/smu_word_ram.sv
// Word store of the segment map/unmap memory unit: one slot of words per segment.
// Single port memory with a registered read; uses smu_pkg for the word width.
`default_nettype none

module smu_word_ram #(
  parameter int MAX_SEGMENTS = smu_pkg::DEF_MAX_SEGMENTS,
  parameter int SLOT_WORDS   = smu_pkg::DEF_SLOT_WORDS
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic                              re,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]   seg,
  input  logic [((SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1)-1:0] offs,
  input  logic [smu_pkg::WORD_W-1:0]        wdata,
  output logic [smu_pkg::WORD_W-1:0]        rdata
);
  import smu_pkg::*;

  localparam longint DEPTH = longint'(MAX_SEGMENTS) * longint'(SLOT_WORDS);
  localparam int     AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [AW-1:0]     addr;
  logic [WORD_W-1:0] rdata_r;

  // Word k of segment s sits at s * SLOT_WORDS + k.
  assign addr = AW'(seg) * AW'(SLOT_WORDS) + AW'(offs);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/smu_tables.sv
// Segment length table and free identifier stack of the memory unit.
// Two small memories with registered reads; uses smu_pkg for widths and strobes.
`default_nettype none

module smu_tables #(
  parameter int MAX_SEGMENTS = smu_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                            clk,
  input  smu_pkg::tbl_ctrl_t              ctrl,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] len_waddr,
  input  logic [smu_pkg::SIZE_W-1:0]      len_wdata,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] len_raddr,
  output logic [smu_pkg::SIZE_W-1:0]      len_q,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] stk_waddr,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] stk_wdata,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] stk_raddr,
  output logic [$clog2(MAX_SEGMENTS)-1:0] stk_q
);
  import smu_pkg::*;

  localparam int ID_W = $clog2(MAX_SEGMENTS);

  logic [SIZE_W-1:0] len_mem [MAX_SEGMENTS];
  logic [ID_W-1:0]   stk_mem [MAX_SEGMENTS];
  logic [SIZE_W-1:0] len_q_r;
  logic [ID_W-1:0]   stk_q_r;

  always_ff @(posedge clk) begin
    if (ctrl.len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_q_r <= len_mem[len_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q_r <= stk_mem[stk_raddr];
  end

  assign len_q = len_q_r;
  assign stk_q = stk_q_r;

endmodule

`default_nettype wire

### sv/segment_map_unmap_memory_unit.sv
// Segmented word memory with LIFO identifier recycling; uses smu_pkg and the three smu_ units.
// Unmap, store and any failed operation go from the check state to done; a load passes
// through the read state (registered word store read) and a map through the fill state, whose
// zero fill writes one word per cycle through the single port of the word store.
// One word is in flight at a time; the next is taken in the cycle after its result registers.
// After reset the length table is cleared entry by entry, with in_stall held high.
`default_nettype none
`include "segment_map_unmap_memory_unit_defines.svh"

module segment_map_unmap_memory_unit #(
  parameter int MAX_SEGMENTS = smu_pkg::DEF_MAX_SEGMENTS,
  parameter int SLOT_WORDS   = smu_pkg::DEF_SLOT_WORDS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [smu_pkg::KIND_W-1:0]   in_kind,
  input  logic [smu_pkg::SEGID_W-1:0]  in_seg_id,
  input  logic [smu_pkg::OFFS_W-1:0]   in_word_offset,
  input  logic [smu_pkg::WORD_W-1:0]   in_write_word,
  input  logic [smu_pkg::SIZE_W-1:0]   in_map_size,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [smu_pkg::WORD_W-1:0]   out_read_word,
  output logic [smu_pkg::SEGID_W-1:0]  out_new_id,
  output logic [smu_pkg::STAT_W-1:0]   out_status
);
  import smu_pkg::*;

  // Identifier width, counter width (counters must hold MAX_SEGMENTS itself),
  // offset width within a slot and width of the shared compare unit.
  localparam int ID_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = ID_W + 1;
  localparam int OFF_W = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
  localparam int CW0   = (CNT_W > OFF_W + 1) ? CNT_W : OFF_W + 1;
  localparam int CMP_W = (CW0 > SIZE_W + 1) ? CW0 : SIZE_W + 1;

  // Sequencer and bookkeeping registers.
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]    next_fresh_r, next_fresh_nxt;
  logic [ID_W-1:0]     clr_r, clr_nxt;
  logic [ID_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_W-1:0]   fill_k_r, fill_k_nxt;

  // The word being worked on, captured at accept.
  logic [KIND_W-1:0]   kind_r;
  logic [SEGID_W-1:0]  id_r;
  logic [OFFS_W-1:0]   off_r;
  logic [WORD_W-1:0]   wval_r;
  logic [SIZE_W-1:0]   size_r;

  // Result under construction and the output register.
  logic [WORD_W-1:0]   res_word_r, res_word_nxt;
  logic [SEGID_W-1:0]  res_nid_r, res_nid_nxt;
  logic [STAT_W-1:0]   res_stat_r, res_stat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_word_r, out_word_nxt;
  logic [SEGID_W-1:0]  out_nid_r, out_nid_nxt;
  logic [STAT_W-1:0]   out_stat_r, out_stat_nxt;

  // Table and word store ports.
  tbl_ctrl_t           tctl;
  logic [ID_W-1:0]     len_waddr, len_raddr, stk_waddr, stk_wdata, stk_raddr;
  logic [SIZE_W-1:0]   len_wdata, len_q;
  logic [ID_W-1:0]     pop_q;
  logic                ram_we, ram_re;
  logic [ID_W-1:0]     ram_seg;
  logic [OFF_W-1:0]    ram_off;
  logic [WORD_W-1:0]   ram_wdata, ram_q;

  // Shared compare and increment unit.
  logic [CMP_W-1:0]    alu_a, alu_b, alu_inc;
  logic                alu_lt;

  logic                in_acc;
  logic                in_id_ok, id_ok;
  logic [ID_W-1:0]     pick;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // An identifier addresses a real segment only below MAX_SEGMENTS.
  assign in_id_ok = (CMP_W'(in_seg_id) < CMP_W'(MAX_SEGMENTS));
  assign id_ok    = (CMP_W'(id_r) < CMP_W'(MAX_SEGMENTS));

  // Both tables are read every cycle.  In the accept cycle the length table
  // is looked up at the incoming identifier and the stack at its top entry,
  // so both values are ready in the check cycle.
  assign len_raddr = in_id_ok ? ID_W'(in_seg_id) : '0;
  assign stk_raddr = ID_W'(free_cnt_r - CNT_W'(1));

  smu_tables #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_tables (
    .clk       (clk),
    .ctrl      (tctl),
    .len_waddr (len_waddr),
    .len_wdata (len_wdata),
    .len_raddr (len_raddr),
    .len_q     (len_q),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (stk_raddr),
    .stk_q     (pop_q)
  );

  smu_word_ram #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SLOT_WORDS   (SLOT_WORDS)
  ) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .seg   (ram_seg),
    .offs  (ram_off),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  smu_alu #(
    .W (CMP_W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .lt  (alu_lt),
    .inc (alu_inc)
  );

  // Capture the incoming word.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      id_r   <= in_seg_id;
      off_r  <= in_word_offset;
      wval_r <= in_write_word;
      size_r <= in_map_size;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      free_cnt_r   <= '0;
      next_fresh_r <= '0;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_cnt_r   <= free_cnt_nxt;
      next_fresh_r <= next_fresh_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working and result payload.
  always_ff @(posedge clk) begin
    pick_r     <= pick_nxt;
    fill_k_r   <= fill_k_nxt;
    res_word_r <= res_word_nxt;
    res_nid_r  <= res_nid_nxt;
    res_stat_r <= res_stat_nxt;
    out_word_r <= out_word_nxt;
    out_nid_r  <= out_nid_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // Sequencer.  Each word goes through a check cycle where one compare
  // that its kind needs runs on the shared unit; a successful map then loops in the
  // fill state, reusing the unit for the bound test and the counter step.
  always_comb begin
    state_nxt      = state_r;
    free_cnt_nxt   = free_cnt_r;
    next_fresh_nxt = next_fresh_r;
    clr_nxt        = clr_r;
    pick_nxt       = pick_r;
    fill_k_nxt     = fill_k_r;
    res_word_nxt   = res_word_r;
    res_nid_nxt    = res_nid_r;
    res_stat_nxt   = res_stat_r;
    out_word_nxt   = out_word_r;
    out_nid_nxt    = out_nid_r;
    out_stat_nxt   = out_stat_r;
    // A waiting result leaves the output register once it is taken.
    out_valid_nxt  = out_valid_r && out_stall;

    tctl      = '0;
    len_waddr = '0;
    len_wdata = '0;
    stk_waddr = ID_W'(free_cnt_r);
    stk_wdata = ID_W'(id_r);
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_seg   = ID_W'(id_r);
    ram_off   = OFF_W'(off_r);
    ram_wdata = wval_r;
    alu_a     = '0;
    alu_b     = '0;
    pick      = pop_q;

    unique case (state_r)
      S_CLEAR: begin
        // One length entry per cycle goes to zero after reset.
        tctl.len_we = 1'b1;
        len_waddr   = clr_r;
        len_wdata   = '0;
        clr_nxt     = clr_r + ID_W'(1);
        if (clr_r == ID_W'(MAX_SEGMENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          res_word_nxt = '0;
          res_nid_nxt  = '0;
          res_stat_nxt = STAT_OK;
          state_nxt    = S_CHECK;
        end
      end

      S_CHECK: begin
        state_nxt = S_DONE;
        unique case (kind_r) inside
          KIND_MAP: begin
            // Size check first, then the identifier: top of the free stack,
            // otherwise the next fresh one.
            alu_a = CMP_W'(SLOT_WORDS);
            alu_b = CMP_W'(size_r);
            if (alu_lt) begin
              res_stat_nxt = STAT_TOO_BIG;
            end else if (free_cnt_r != '0) begin
              pick         = pop_q;
              free_cnt_nxt = free_cnt_r - CNT_W'(1);
            end else if (next_fresh_r < CNT_W'(MAX_SEGMENTS)) begin
              pick           = ID_W'(next_fresh_r);
              next_fresh_nxt = next_fresh_r + CNT_W'(1);
            end else begin
              res_stat_nxt = STAT_NO_ID;
            end
            if (!alu_lt && (free_cnt_r != '0 || next_fresh_r < CNT_W'(MAX_SEGMENTS))) begin
              tctl.len_we = 1'b1;
              len_waddr   = pick;
              len_wdata   = size_r;
              pick_nxt    = pick;
              res_nid_nxt = SEGID_W'(pick);
              fill_k_nxt  = '0;
              state_nxt   = S_FILL;
            end
          end

          KIND_UNMAP: begin
            // Only identifiers already handed out may be freed; a free one
            // is pushed again without complaint.
            alu_a = CMP_W'(id_r);
            alu_b = CMP_W'(next_fresh_r);
            if (!alu_lt) begin
              res_stat_nxt = STAT_RANGE;
            end else if (free_cnt_r == CNT_W'(MAX_SEGMENTS)) begin
              res_stat_nxt = STAT_STACK_FULL;
            end else begin
              tctl.len_we  = 1'b1;
              len_waddr    = ID_W'(id_r);
              len_wdata    = '0;
              tctl.stk_we  = 1'b1;
              free_cnt_nxt = free_cnt_r + CNT_W'(1);
            end
          end

          KIND_STORE, KIND_LOAD: begin
            alu_a = CMP_W'(off_r);
            alu_b = CMP_W'(len_q);
            if (!id_ok || !alu_lt) begin
              res_stat_nxt = STAT_RANGE;
            end else if (kind_r == KIND_STORE) begin
              ram_we = 1'b1;
            end else begin
              ram_re    = 1'b1;
              state_nxt = S_READ;
            end
          end
        endcase
      end

      S_FILL: begin
        // Zero one word per cycle until the counter reaches the size.
        alu_a = CMP_W'(fill_k_r);
        alu_b = CMP_W'(size_r);
        if (alu_lt) begin
          ram_we     = 1'b1;
          ram_seg    = pick_r;
          ram_off    = OFF_W'(fill_k_r);
          ram_wdata  = '0;
          fill_k_nxt = SIZE_W'(alu_inc);
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_READ: begin
        res_word_nxt = ram_q;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        // Hand the result over as soon as the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_word_nxt  = res_word_r;
          out_nid_nxt   = res_nid_r;
          out_stat_nxt  = res_stat_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_read_word = out_word_r;
  assign out_new_id    = out_nid_r;
  assign out_status    = out_stat_r;

  // The free stack never holds more identifiers than exist.
  `SMU_ASSERT_IMP(a_free_cnt_bound, 1'b1, free_cnt_r <= CNT_W'(MAX_SEGMENTS),
                  "free stack count exceeds segment count")
  // Fresh identifiers stop at the segment count.
  `SMU_ASSERT_IMP(a_fresh_bound, 1'b1, next_fresh_r <= CNT_W'(MAX_SEGMENTS),
                  "fresh identifier counter overran")
  // The fill counter never passes the requested size.
  `SMU_ASSERT_IMP(a_fill_bound, state_r == S_FILL, fill_k_r <= size_r,
                  "zero fill ran past the segment size")
  // A result appears only out of the done state.
  `SMU_ASSERT_IMP(a_result_src, $rose(out_valid_r), $past(state_r) == S_DONE,
                  "result registered outside the done state")
  // Read data is taken in the cycle after the load issues.
  `SMU_ASSERT_NXT(a_read_done, state_r == S_READ, state_r == S_DONE,
                  "load did not complete after its read cycle")

endmodule

`default_nettype wire
